### src/ccm_pkg.sv
// ----------------------------------------------------------------------------
// ccm_pkg
// Types, codes and calendar helpers for the calendar clock cron matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

  // Field widths of the clock and of one rule entry.
  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINUTE_W  = 6;
  localparam int unsigned WDAY_W    = 3;
  localparam int unsigned RCOUNT_W  = 4;
  localparam int unsigned RIDX_W    = 3;

  localparam logic [YEAR_W-1:0]   YEAR_MIN   = 14'd1970;
  localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
  localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
  localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
  localparam logic [DAY_W-1:0]    DAY_MAX    = 5'd31;
  localparam logic [WDAY_W-1:0]   WDAY_MAX   = 3'd6;
  localparam logic [WDAY_W-1:0]   WDAY_EPOCH = 3'd4;

  // Rounded 2^17/25; exact floor(q/25) for any q below 2500.
  localparam logic [12:0] RECIP_25 = 13'd5243;
  // Folds the 1970 origin, the leap years up to 1969, the Thursday offset
  // and the one-based day into a single bias.
  localparam logic [14:0] DAY_BIAS = 15'd2444;

  typedef enum logic [1:0] {
    OP_SET_TIME  = 2'd0,
    OP_LOAD_RULE = 2'd1,
    OP_TICK      = 2'd2
  } ccm_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_ADVANCE,
    ST_LEAP_MUL,
    ST_LEAP_EVAL,
    ST_PREV_MUL,
    ST_DAYS,
    ST_WDAY
  } ccm_state_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [RIDX_W-1:0]   rule_index;
    logic [59:0]         minute_mask;
    logic [23:0]         hour_mask;
    logic [30:0]         day_mask;
    logic [11:0]         month_mask;
    logic [6:0]          weekday_mask;
    logic [YEAR_W-1:0]   set_year;
    logic [MONTH_W-1:0]  set_month;
    logic [DAY_W-1:0]    set_day;
    logic [HOUR_W-1:0]   set_hour;
    logic [MINUTE_W-1:0] set_minute;
  } ccm_in_t;

  typedef struct packed {
    logic [RIDX_W-1:0]   matched_rule;
    logic [YEAR_W-1:0]   fire_year;
    logic [MONTH_W-1:0]  fire_month;
    logic [DAY_W-1:0]    fire_day;
    logic [HOUR_W-1:0]   fire_hour;
    logic [MINUTE_W-1:0] fire_minute;
    logic                last_match;
  } ccm_out_t;

  typedef struct packed {
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] day_mask;
    logic [11:0] month_mask;
    logic [6:0]  weekday_mask;
  } ccm_rule_t;

  function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] s;
    case (m)
      4'd2:    s = 9'd31;
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Since 8 is 1 modulo 7, the octal digits sum to the same residue.
  function automatic logic [WDAY_W-1:0] mod7(input logic [YEAR_W-1:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[13:12]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

`default_nettype wire

### src/ccm_ram.sv
// ----------------------------------------------------------------------------
// ccm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/calendar_clock_cron_matcher.sv
// Tick: one RAM read per active rule; a stalled output stops the scan, and a
// year rollover adds the ST_LEAP_MUL and ST_LEAP_EVAL states.
// Set time: the shared reciprocal multiplier serves the leap year and weekday
// terms. Load rule: written in the accepting cycle. One word is in work at a time.
// Reset: clock 1970-01-01 00:00 Thursday, rule_count 0, no result pending;
// the rule RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// calendar_clock_cron_matcher
// Minute calendar clock with a RAM-held table of cron-style rule masks.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_cron_matcher
  import ccm_pkg::*;
#(
  parameter int unsigned NUM_RULES = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ccm_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ccm_out_t                 out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [RCOUNT_W-1:0] cfg_data_i
);

  localparam int unsigned AW     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int unsigned RULE_W = $bits(ccm_rule_t);

  ccm_state_e          state_q, state_d;
  logic                set_mode_q, set_mode_d;
  logic [RCOUNT_W-1:0] rule_count_q;

  logic [YEAR_W-1:0]   year_q, year_d;
  logic [MONTH_W-1:0]  month_q, month_d;
  logic [DAY_W-1:0]    day_q, day_d;
  logic [HOUR_W-1:0]   hour_q, hour_d;
  logic [MINUTE_W-1:0] minute_q, minute_d;
  logic [WDAY_W-1:0]   wday_q, wday_d;
  logic                leap_q, leap_d;

  logic [DAY_W-1:0]    day_raw_q, day_raw_d;
  logic [11:0]         mq_q, mq_d;
  logic [24:0]         prod_q, prod_d;
  logic [YEAR_W-1:0]   t_q, t_d;

  logic [RCOUNT_W-1:0] issue_idx_q, issue_idx_d;
  logic [RCOUNT_W-1:0] eval_idx_q, eval_idx_d;
  logic                eval_valid_q, eval_valid_d;
  logic [RCOUNT_W-1:0] pend_idx_q, pend_idx_d;
  logic                pend_valid_q, pend_valid_d;

  logic                out_valid_q, out_valid_d;
  ccm_out_t            out_data_q, out_data_d;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [RULE_W-1:0]   ram_rdata;
  ccm_rule_t           rd_rule, wr_rule;

  logic [RCOUNT_W-1:0] active;
  logic [DAY_W-1:0]    dm;
  logic [YEAR_W-1:0]   year_m1;
  logic [7:0]          quot;
  logic                hit, stall, issue, out_free, push, push_last;
  logic [14:0]         t_sum;
  logic                at_end;

  assign wr_rule = '{
    minute_mask:  in_data_i.minute_mask,
    hour_mask:    in_data_i.hour_mask,
    day_mask:     in_data_i.day_mask,
    month_mask:   in_data_i.month_mask,
    weekday_mask: in_data_i.weekday_mask
  };

  ccm_ram #(
    .WIDTH (RULE_W),
    .DEPTH (NUM_RULES),
    .AW    (AW)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_rule),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_rule   = ram_rdata;
  assign ram_waddr = AW'(in_data_i.rule_index);
  assign ram_raddr = AW'(issue_idx_q);

  assign active  = ({3'b0, rule_count_q} > 7'(NUM_RULES)) ? RCOUNT_W'(NUM_RULES)
                                                         : rule_count_q;
  assign dm      = days_in_month(leap_q, month_q);
  assign year_m1 = year_q - 14'd1;
  assign quot    = prod_q[24:17];

  assign hit = eval_valid_q &&
               rd_rule.minute_mask[minute_q] &&
               rd_rule.hour_mask[hour_q] &&
               rd_rule.day_mask[5'(day_q - 5'd1)] &&
               rd_rule.month_mask[4'(month_q - 4'd1)] &&
               rd_rule.weekday_mask[wday_q];

  assign out_free = !out_valid_q || out_ready_i;
  assign stall    = (state_q == ST_SCAN) && hit && pend_valid_q && !out_free;
  assign issue    = (state_q == ST_SCAN) && (issue_idx_q < active) && !stall;
  assign ram_re   = issue;

  assign at_end = (year_q == YEAR_MAX) && (month_q == MONTH_MAX) && (day_q == DAY_MAX) &&
                  (hour_q == HOUR_MAX) && (minute_q == MINUTE_MAX);

  assign t_sum = 15'(year_q) + 15'(mq_q) - 15'(quot) + 15'(quot[7:2]) +
                 15'(month_start(month_q)) +
                 15'((month_q > 4'd2) && leap_q) + 15'(day_q) - DAY_BIAS;

  always_comb begin
    state_d      = state_q;
    set_mode_d   = set_mode_q;
    year_d       = year_q;
    month_d      = month_q;
    day_d        = day_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    wday_d       = wday_q;
    leap_d       = leap_q;
    day_raw_d    = day_raw_q;
    mq_d         = mq_q;
    prod_d       = prod_q;
    t_d          = t_q;
    issue_idx_d  = issue_idx_q;
    eval_idx_d   = eval_idx_q;
    eval_valid_d = eval_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_valid_d = pend_valid_q;
    push         = 1'b0;
    push_last    = 1'b0;
    ram_we       = 1'b0;
    in_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_data_i.opcode)
            OP_SET_TIME: begin
              if (in_data_i.set_year < YEAR_MIN) begin
                year_d = YEAR_MIN;
              end else if (in_data_i.set_year > YEAR_MAX) begin
                year_d = YEAR_MAX;
              end else begin
                year_d = in_data_i.set_year;
              end
              if (in_data_i.set_month == 4'd0) begin
                month_d = 4'd1;
              end else if (in_data_i.set_month > MONTH_MAX) begin
                month_d = MONTH_MAX;
              end else begin
                month_d = in_data_i.set_month;
              end
              hour_d     = (in_data_i.set_hour > HOUR_MAX) ? HOUR_MAX : in_data_i.set_hour;
              minute_d   = (in_data_i.set_minute > MINUTE_MAX) ? MINUTE_MAX
                                                               : in_data_i.set_minute;
              day_raw_d  = in_data_i.set_day;
              set_mode_d = 1'b1;
              state_d    = ST_LEAP_MUL;
            end
            OP_LOAD_RULE: begin
              ram_we = ({4'b0, in_data_i.rule_index} < 7'(NUM_RULES));
            end
            OP_TICK: begin
              issue_idx_d  = '0;
              eval_valid_d = 1'b0;
              pend_valid_d = 1'b0;
              state_d      = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // The RAM returns entry eval_idx_q while the next entry is requested.
        if (!stall) begin
          eval_valid_d = issue;
          eval_idx_d   = issue_idx_q;
          if (issue) begin
            issue_idx_d = issue_idx_q + 4'd1;
          end
          if (hit) begin
            push         = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_idx_d   = eval_idx_q;
          end
          if (!issue && !eval_valid_q) begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_FINISH: begin
        if (!pend_valid_q || out_free) begin
          push         = pend_valid_q;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_ADVANCE;
        end
      end

      ST_ADVANCE: begin
        state_d = ST_IDLE;
        if (!at_end) begin
          if (minute_q < MINUTE_MAX) begin
            minute_d = minute_q + 6'd1;
          end else begin
            minute_d = '0;
            if (hour_q < HOUR_MAX) begin
              hour_d = hour_q + 5'd1;
            end else begin
              hour_d = '0;
              wday_d = (wday_q == WDAY_MAX) ? '0 : wday_q + 3'd1;
              if (day_q < dm) begin
                day_d = day_q + 5'd1;
              end else begin
                day_d = 5'd1;
                if (month_q < MONTH_MAX) begin
                  month_d = month_q + 4'd1;
                end else begin
                  month_d    = 4'd1;
                  year_d     = year_q + 14'd1;
                  set_mode_d = 1'b0;
                  state_d    = ST_LEAP_MUL;
                end
              end
            end
          end
        end
      end

      ST_LEAP_MUL: begin
        mq_d    = year_q[13:2];
        prod_d  = {13'b0, year_q[13:2]} * {12'b0, RECIP_25};
        state_d = ST_LEAP_EVAL;
      end

      ST_LEAP_EVAL: begin
        // quot is year/100; a century is a leap year only when year/100 % 4 is 0.
        leap_d  = (year_q[1:0] == 2'd0) &&
                  (({1'b0, year_q} != (15'(quot) * 15'd100)) || (quot[1:0] == 2'd0));
        state_d = set_mode_q ? ST_PREV_MUL : ST_IDLE;
      end

      ST_PREV_MUL: begin
        if (day_raw_q == 5'd0) begin
          day_d = 5'd1;
        end else if (day_raw_q > dm) begin
          day_d = dm;
        end else begin
          day_d = day_raw_q;
        end
        mq_d    = year_m1[13:2];
        prod_d  = {13'b0, year_m1[13:2]} * {12'b0, RECIP_25};
        state_d = ST_DAYS;
      end

      ST_DAYS: begin
        t_d     = t_sum[YEAR_W-1:0];
        state_d = ST_WDAY;
      end

      ST_WDAY: begin
        wday_d     = mod7(t_q);
        set_mode_d = 1'b0;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_data_d  = '{
        matched_rule: pend_idx_q[RIDX_W-1:0],
        fire_year:    year_q,
        fire_month:   month_q,
        fire_day:     day_q,
        fire_hour:    hour_q,
        fire_minute:  minute_q,
        last_match:   push_last
      };
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      set_mode_q   <= 1'b0;
      rule_count_q <= '0;
      year_q       <= YEAR_MIN;
      month_q      <= 4'd1;
      day_q        <= 5'd1;
      hour_q       <= '0;
      minute_q     <= '0;
      wday_q       <= WDAY_EPOCH;
      leap_q       <= 1'b0;
      issue_idx_q  <= '0;
      eval_valid_q <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      set_mode_q   <= set_mode_d;
      if (cfg_we_i) begin
        rule_count_q <= cfg_data_i;
      end
      year_q       <= year_d;
      month_q      <= month_d;
      day_q        <= day_d;
      hour_q       <= hour_d;
      minute_q     <= minute_d;
      wday_q       <= wday_d;
      leap_q       <= leap_d;
      issue_idx_q  <= issue_idx_d;
      eval_valid_q <= eval_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_raw_q  <= day_raw_d;
    mq_q       <= mq_d;
    prod_q     <= prod_d;
    t_q        <= t_d;
    eval_idx_q <= eval_idx_d;
    pend_idx_q <= pend_idx_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

### tb/calendar_clock_cron_matcher_tb.sv
// ----------------------------------------------------------------------------
// calendar_clock_cron_matcher_tb
// Self-checking bench for the cron matcher. A directed table covers reset,
// saturation of the set-time fields, the end of the calendar, leap years and
// rollovers. Random phases follow with different rule counts and idle
// patterns. A behavioral calendar in the bench predicts the fire words that the directed table does not give.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_clock_cron_matcher_tb
  import ccm_pkg::*;
();

  localparam int NUM_RULES      = 8;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_WORDS    = 55;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int MONTH_LEN   [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct {
    ccm_in_t  word;
    bit       typed;
    ccm_out_t fire;
  } step_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  ccm_in_t             in_data   = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ccm_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [RCOUNT_W-1:0] cfg_data  = '0;

  // Predicted calendar state and rule table.
  logic [YEAR_W-1:0]   now_year   = YEAR_MIN;
  logic [MONTH_W-1:0]  now_month  = 4'd1;
  logic [DAY_W-1:0]    now_day    = 5'd1;
  logic [HOUR_W-1:0]   now_hour   = '0;
  logic [MINUTE_W-1:0] now_minute = '0;
  logic [WDAY_W-1:0]   now_wday   = WDAY_EPOCH;
  logic [RCOUNT_W-1:0] active_rules = '0;
  ccm_rule_t           rule_tab [NUM_RULES];

  ccm_out_t  pending_fires [$];
  step_row_t directed_rows [$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  int        quiet_cycles   = 0;

  calendar_clock_cron_matcher #(
    .NUM_RULES(NUM_RULES)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- calendar

  function automatic bit is_leap(input int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int month_days(input int y, input int m);
    return (m == 2 && is_leap(y)) ? 29 : MONTH_LEN[m-1];
  endfunction

  function automatic int leaps_thru(input int y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Counts days from 1970-01-01, which fell on a Thursday.
  function automatic logic [WDAY_W-1:0] weekday_from_date(input int y, input int m, input int d);
    int days;
    days = 365 * (y - 1970) + leaps_thru(y - 1) - leaps_thru(1969) + MONTH_START[m-1] +
           ((m > 2 && is_leap(y)) ? 1 : 0) + d - 1;
    return WDAY_W'((days % 7 + 4) % 7);
  endfunction

  function automatic void step_minute();
    if (now_year == YEAR_MAX && now_month == MONTH_MAX && now_day == DAY_MAX &&
        now_hour == HOUR_MAX && now_minute == MINUTE_MAX) begin
      return;
    end
    if (now_minute != MINUTE_MAX) begin
      now_minute = now_minute + 1'b1;
      return;
    end
    now_minute = '0;
    if (now_hour != HOUR_MAX) begin
      now_hour = now_hour + 1'b1;
      return;
    end
    now_hour = '0;
    now_wday = (now_wday == WDAY_MAX) ? '0 : now_wday + 1'b1;
    if (int'(now_day) < month_days(now_year, now_month)) begin
      now_day = now_day + 1'b1;
      return;
    end
    now_day = 5'd1;
    if (now_month != MONTH_MAX) begin
      now_month = now_month + 1'b1;
      return;
    end
    now_month = 4'd1;
    now_year  = now_year + 1'b1;
  endfunction

  // Applies one accepted word to the predicted state and returns its fire words.
  function automatic int apply_word(input ccm_in_t w, output ccm_out_t fires [NUM_RULES]);
    int y, m, d, h, mi, lim, i, n;
    n = 0;
    for (i = 0; i < NUM_RULES; i++) begin
      fires[i] = '0;
    end
    case (w.opcode)
      OP_SET_TIME: begin
        y  = int'(w.set_year);
        m  = int'(w.set_month);
        d  = int'(w.set_day);
        h  = int'(w.set_hour);
        mi = int'(w.set_minute);
        if (y < int'(YEAR_MIN)) y = int'(YEAR_MIN);
        if (y > int'(YEAR_MAX)) y = int'(YEAR_MAX);
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        lim = month_days(y, m);
        if (d < 1) d = 1;
        if (d > lim) d = lim;
        if (h > 23) h = 23;
        if (mi > 59) mi = 59;
        now_year   = YEAR_W'(y);
        now_month  = MONTH_W'(m);
        now_day    = DAY_W'(d);
        now_hour   = HOUR_W'(h);
        now_minute = MINUTE_W'(mi);
        now_wday   = weekday_from_date(y, m, d);
      end
      OP_LOAD_RULE: begin
        rule_tab[w.rule_index] = '{w.minute_mask, w.hour_mask, w.day_mask,
                                   w.month_mask, w.weekday_mask};
      end
      OP_TICK: begin
        lim = (int'(active_rules) > NUM_RULES) ? NUM_RULES : int'(active_rules);
        for (i = 0; i < lim; i++) begin
          if (rule_tab[i].minute_mask[now_minute] && rule_tab[i].hour_mask[now_hour] &&
              rule_tab[i].day_mask[now_day - 1'b1] &&
              rule_tab[i].month_mask[now_month - 1'b1] &&
              rule_tab[i].weekday_mask[now_wday]) begin
            fires[n].matched_rule = RIDX_W'(i);
            fires[n].fire_year    = now_year;
            fires[n].fire_month   = now_month;
            fires[n].fire_day     = now_day;
            fires[n].fire_hour    = now_hour;
            fires[n].fire_minute  = now_minute;
            fires[n].last_match   = 1'b0;
            n++;
          end
        end
        if (n > 0) begin
          fires[n-1].last_match = 1'b1;
        end
        step_minute();
      end
      default: ;
    endcase
    return n;
  endfunction

  // ------------------------------------------------------------- word makers

  function automatic ccm_in_t rand_word();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(ccm_in_t)-1:0];
  endfunction

  function automatic ccm_in_t op_word(input logic [1:0] op);
    ccm_in_t w;
    w = rand_word();
    w.opcode = op;
    return w;
  endfunction

  function automatic ccm_in_t set_word(input int y, input int m, input int d,
                                       input int h, input int mi);
    ccm_in_t w;
    w = op_word(OP_SET_TIME);
    w.set_year   = YEAR_W'(y);
    w.set_month  = MONTH_W'(m);
    w.set_day    = DAY_W'(d);
    w.set_hour   = HOUR_W'(h);
    w.set_minute = MINUTE_W'(mi);
    return w;
  endfunction

  function automatic ccm_in_t rule_word(input int idx, input logic [59:0] mm,
                                        input logic [23:0] hm, input logic [30:0] dm,
                                        input logic [11:0] mom, input logic [6:0] wm);
    ccm_in_t w;
    w = op_word(OP_LOAD_RULE);
    w.rule_index   = RIDX_W'(idx);
    w.minute_mask  = mm;
    w.hour_mask    = hm;
    w.day_mask     = dm;
    w.month_mask   = mom;
    w.weekday_mask = wm;
    return w;
  endfunction

  function automatic ccm_out_t fire_at(input int rule, input int y, input int m, input int d,
                                       input int h, input int mi);
    ccm_out_t f;
    f.matched_rule = RIDX_W'(rule);
    f.fire_year    = YEAR_W'(y);
    f.fire_month   = MONTH_W'(m);
    f.fire_day     = DAY_W'(d);
    f.fire_hour    = HOUR_W'(h);
    f.fire_minute  = MINUTE_W'(mi);
    f.last_match   = 1'b1;
    return f;
  endfunction

  // Dense masks make most ticks fire several rules.
  function automatic logic [63:0] thicken(input logic [63:0] m);
    case ($urandom_range(3))
      0:       return m;
      3:       return '1;
      default: return m | {$urandom, $urandom} | {$urandom, $urandom};
    endcase
  endfunction

  function automatic ccm_in_t random_rule_word(input int idx);
    return rule_word(idx, 60'(thicken({$urandom, $urandom})), 24'(thicken({$urandom, $urandom})),
                     31'(thicken({$urandom, $urandom})), 12'(thicken({$urandom, $urandom})),
                     7'(thicken({$urandom, $urandom})));
  endfunction

  function automatic ccm_in_t random_word();
    ccm_in_t w;
    int sel, y, m;
    sel = $urandom_range(99);
    if (sel < 62) begin
      w = op_word(OP_TICK);
    end else if (sel < 80) begin
      w = random_rule_word($urandom_range(NUM_RULES - 1));
    end else if (sel < 96) begin
      w = op_word(OP_SET_TIME);
      // A quarter keep raw field values to exercise saturation; the rest are
      // valid dates close to a rollover.
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(4))
          0:       y = int'(YEAR_MIN);
          1:       y = int'(YEAR_MAX);
          2:       y = $urandom_range(2001, 1999);
          3:       y = 100 * $urandom_range(99, 20);
          default: y = $urandom_range(9999, 1970);
        endcase
        m = $urandom_range(12, 1);
        if (y == int'(YEAR_MAX) && $urandom_range(1)) m = 12;
        w.set_year  = YEAR_W'(y);
        w.set_month = MONTH_W'(m);
        w.set_day   = $urandom_range(1) ? DAY_W'(month_days(y, m))
                                        : DAY_W'($urandom_range(month_days(y, m), 1));
        w.set_hour   = $urandom_range(1) ? HOUR_MAX : HOUR_W'($urandom_range(23));
        w.set_minute = $urandom_range(1) ? MINUTE_MAX : MINUTE_W'($urandom_range(59, 55));
      end
    end else begin
      w = op_word(OP_RESERVED);
    end
    return w;
  endfunction

  function automatic void add_row(input ccm_in_t w, input bit typed, input ccm_out_t fire);
    step_row_t row;
    row.word  = w;
    row.typed = typed;
    row.fire  = fire;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // ------------------------------------------------------------------ driving

  task automatic send_word(input ccm_in_t w, input bit typed, input ccm_out_t typed_fire);
    ccm_out_t fires [NUM_RULES];
    int n, i;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = apply_word(w, fires);
    if (typed) begin
      pending_fires.insert(pending_fires.size(), typed_fire);
    end else begin
      for (i = 0; i < n; i++) begin
        pending_fires.insert(pending_fires.size(), fires[i]);
      end
    end
  endtask

  // A tick that fires nothing may still be in work once the queue is empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_fires.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_rule_count(input logic [RCOUNT_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    active_rules  = v;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ----------------------------------------------------------------- checking

  function automatic string fire_str(input ccm_out_t f);
    return $sformatf("rule %0d at %0d-%0d-%0d %0d:%0d last %0d", f.matched_rule, f.fire_year,
                     f.fire_month, f.fire_day, f.fire_hour, f.fire_minute, f.last_match);
  endfunction

  always @(posedge clk) begin
    ccm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_fires.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected word: %s", fire_str(out_data));
      end else begin
        want = pending_fires.pop_front();
        if (want.matched_rule !== out_data.matched_rule || want.fire_year !== out_data.fire_year ||
            want.fire_month !== out_data.fire_month || want.fire_day !== out_data.fire_day ||
            want.fire_hour !== out_data.fire_hour ||
            want.fire_minute !== out_data.fire_minute ||
            want.last_match !== out_data.last_match) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected %s, got %s", fire_str(want), fire_str(out_data));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ------------------------------------------------------------------ stimulus

  initial begin
    logic [RCOUNT_W-1:0] phase_counts [6];
    int                  k, ph;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_rule_count(4'd1);

    add_row(rule_word(0, '1, '1, '1, '1, '1), 1'b0, '0);
    add_row(op_word(OP_TICK), 1'b1, fire_at(0, 1970, 1, 1, 0, 0));
    add_row(op_word(OP_TICK), 1'b0, '0);
    // All-zero and all-one time fields both saturate.
    add_row(set_word(0, 0, 0, 0, 0), 1'b0, '0);
    add_row(op_word(OP_TICK), 1'b1, fire_at(0, 1970, 1, 1, 0, 0));
    add_row(set_word(16383, 15, 31, 31, 63), 1'b0, '0);
    // The last minute of the calendar fires but never advances.
    add_row(op_word(OP_TICK), 1'b1, fire_at(0, 9999, 12, 31, 23, 59));
    add_row(op_word(OP_TICK), 1'b1, fire_at(0, 9999, 12, 31, 23, 59));
    add_row(set_word(2024, 2, 28, 23, 59), 1'b0, '0);
    add_row(op_word(OP_TICK), 1'b1, fire_at(0, 2024, 2, 28, 23, 59));
    add_row(op_word(OP_TICK), 1'b0, '0);
    add_row(set_word(2100, 2, 28, 23, 59), 1'b0, '0);
    add_row(op_word(OP_TICK), 1'b0, '0);
    add_row(op_word(OP_TICK), 1'b0, '0);
    add_row(set_word(2023, 2, 31, 10, 30), 1'b0, '0);
    add_row(rule_word(0, '1, '1, '1, '1, 7'b0000100), 1'b0, '0);
    add_row(op_word(OP_TICK), 1'b0, '0);
    add_row(rule_word(0, '0, '0, '0, '0, '0), 1'b0, '0);
    add_row(op_word(OP_TICK), 1'b0, '0);
    add_row(op_word(OP_RESERVED), 1'b0, '0);
    add_row(set_word(1999, 12, 31, 23, 59), 1'b0, '0);
    add_row(rule_word(0, 60'h800000000000000, 24'h800000, 31'h40000000, 12'h800, '1),
            1'b0, '0);
    add_row(op_word(OP_TICK), 1'b0, '0);
    add_row(op_word(OP_TICK), 1'b0, '0);

    foreach (directed_rows[k]) begin
      send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].fire);
    end

    // Every entry is loaded before a larger rule count can reach it.
    for (k = 0; k < NUM_RULES; k++) begin
      send_word(random_rule_word(k), 1'b0, '0);
    end

    phase_counts = '{4'd8, 4'd15, 4'd0, RCOUNT_W'($urandom_range(15, 1)), 4'd3, 4'd8};
    for (ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_rule_count(phase_counts[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 1 && k == PHASE_WORDS / 2) wait_drained();
        send_word(random_word(), 1'b0, '0);
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
